>>> hdl/nlt_pkg.sv
// Shared types, codes and character helpers for the numeric literal tokenizer.
// No dependencies; every other file of the block imports this package.
package nlt_pkg;

   localparam int OFFSET_BITS_DEF = 16;
   localparam int TOK_W           = 16;

   typedef enum logic [2:0] {
      TK_PLUS    = 3'd0,
      TK_MINUS   = 3'd1,
      TK_SEMI    = 3'd2,
      TK_INT     = 3'd3,
      TK_FLOAT   = 3'd4,
      TK_INVALID = 3'd5,
      TK_END     = 3'd6
   } token_kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       char_valid;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      token_kind_type     token_kind;
      logic [TOK_W-1:0]   token_start;
      logic [TOK_W-1:0]   token_length;
      logic               last_result;
   } rsp_type;

   // Scanner phases, one-hot
   typedef enum logic [10:0] {
      PH_IDLE = 11'b000_0000_0001,
      PH_INT  = 11'b000_0000_0010,
      PH_DOT  = 11'b000_0000_0100,
      PH_FRAC = 11'b000_0000_1000,
      PH_F    = 11'b000_0001_0000,
      PH_F3   = 11'b000_0010_0000,
      PH_F6   = 11'b000_0100_0000,
      PH_SU   = 11'b000_1000_0000,
      PH_SU1  = 11'b001_0000_0000,
      PH_SU3  = 11'b010_0000_0000,
      PH_SU6  = 11'b100_0000_0000
   } scan_phase_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic sym_avail;
      logic step_block;
      logic stg_valid;
      logic out_free;
   } dp_status_type;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_2     = 8'h32;
   localparam logic [7:0] CH_3     = 8'h33;
   localparam logic [7:0] CH_4     = 8'h34;
   localparam logic [7:0] CH_6     = 8'h36;
   localparam logic [7:0] CH_8     = 8'h38;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_NUL   = 8'h00;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   // space, tab, line feed, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

endpackage

>>> hdl/nlt_ctrl.sv
// Sequencing controller of the numeric literal tokenizer: takes a request,
// steps the datapath symbol by symbol, then releases the held token. Uses nlt_pkg.
module nlt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  nlt_pkg::dp_status_type status,
   output nlt_pkg::dp_cmd_type    cmd
);
   import nlt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.sym_avail) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.step = !status.step_block;
            end
         end
         ST_FLUSH: begin
            // release the held token marked as the last of this request
            if (!status.stg_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/nlt_dp.sv
// Datapath of the numeric literal tokenizer: scanner state, lookahead store,
// replay pointer, held token and output register. Uses nlt_pkg.
module nlt_dp #(
   parameter int OFFSET_BITS = nlt_pkg::OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nlt_pkg::dp_cmd_type    cmd,
   output nlt_pkg::dp_status_type status,
   input  nlt_pkg::req_type       req_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output nlt_pkg::rsp_type       rsp_data
);
   import nlt_pkg::*;

   localparam int OFF_W = (OFFSET_BITS < TOK_W) ? OFFSET_BITS : TOK_W;
   localparam int LA_N  = 3;

   typedef struct packed {
      token_kind_type   kind;
      logic [TOK_W-1:0] start;
      logic [TOK_W-1:0] len;
   } token_type;

   // scanner state
   logic [OFF_W-1:0]  off_ff;
   scan_phase_type    phase_ff;
   logic [TOK_W-1:0]  lit_start_ff;
   logic [TOK_W-1:0]  lit_len_ff;
   logic              lit_float_ff;
   logic [7:0]        la_chr_ff [LA_N];
   logic [TOK_W-1:0]  la_off_ff [LA_N];
   logic [1:0]        la_cnt_ff;
   logic [1:0]        rp_ff;
   logic [1:0]        rcnt_ff;

   // request being worked on
   logic [7:0]        in_chr_ff;
   logic [TOK_W-1:0]  in_off_ff;
   logic              chr_pend_ff;
   logic              end_pend_ff;

   // held token and output register
   token_type         stg_ff;
   logic              stg_vld_ff;
   rsp_type           out_ff;
   logic              out_vld_ff;

   // current symbol
   logic              from_replay, from_chr, sym_end;
   logic [7:0]        sym_chr;
   logic [TOK_W-1:0]  sym_off;

   // scan decision
   logic              sc_consume, sc_emit, sc_fail, sc_hold, sc_begin;
   logic              sc_la_clr, sc_set_float, sc_lit_tok, sc_end_done;
   logic [1:0]        sc_grow;
   scan_phase_type    sc_phase;
   token_kind_type    sc_kind;
   logic [TOK_W-1:0]  sc_len;
   logic [TOK_W:0]    len_sum;
   logic [TOK_W-1:0]  len_grown;
   token_type         tok;
   logic              out_free;

   always_comb begin
      from_replay = rp_ff < rcnt_ff;
      from_chr    = !from_replay && chr_pend_ff;
      sym_end     = !from_replay && !chr_pend_ff && end_pend_ff;
      if (from_replay) begin
         sym_chr = la_chr_ff[rp_ff];
         sym_off = la_off_ff[rp_ff];
      end else if (chr_pend_ff) begin
         sym_chr = in_chr_ff;
         sym_off = in_off_ff;
      end else begin
         // end marker: NUL matches no character class
         sym_chr = CH_NUL;
         sym_off = TOK_W'(off_ff);
      end
   end

   always_comb begin
      sc_consume   = 1'b1;
      sc_emit      = 1'b0;
      sc_fail      = 1'b0;
      sc_hold      = 1'b0;
      sc_begin     = 1'b0;
      sc_la_clr    = 1'b0;
      sc_set_float = 1'b0;
      sc_lit_tok   = 1'b0;
      sc_grow      = 2'd0;
      sc_phase     = phase_ff;
      sc_kind      = TK_INVALID;
      sc_len       = '0;
      unique case (phase_ff)
         PH_IDLE: begin
            priority if (sym_end) begin
               sc_emit = 1'b1;
               sc_kind = TK_END;
            end else if (is_space(sym_chr)) begin
               sc_emit = 1'b0;
            end else if (sym_chr == CH_PLUS) begin
               sc_emit = 1'b1;
               sc_kind = TK_PLUS;
               sc_len  = TOK_W'(1);
            end else if (sym_chr == CH_MINUS) begin
               sc_emit = 1'b1;
               sc_kind = TK_MINUS;
               sc_len  = TOK_W'(1);
            end else if (sym_chr == CH_SEMI) begin
               sc_emit = 1'b1;
               sc_kind = TK_SEMI;
               sc_len  = TOK_W'(1);
            end else if (is_digit(sym_chr)) begin
               sc_begin = 1'b1;
               sc_phase = PH_INT;
            end else begin
               sc_emit = 1'b1;
               sc_kind = TK_INVALID;
            end
         end
         PH_INT: begin
            priority if (is_digit(sym_chr)) begin
               sc_grow = 2'd1;
            end else if (sym_chr == CH_DOT) begin
               sc_hold  = 1'b1;
               sc_phase = PH_DOT;
            end else if (sym_chr == CH_F) begin
               sc_grow      = 2'd1;
               sc_set_float = 1'b1;
               sc_phase     = PH_F;
            end else if ((sym_chr == CH_S) || (sym_chr == CH_U)) begin
               sc_hold  = 1'b1;
               sc_phase = PH_SU;
            end else begin
               sc_fail = 1'b1;
            end
         end
         PH_DOT: begin
            if (is_digit(sym_chr)) begin
               sc_grow      = 2'd2;
               sc_la_clr    = 1'b1;
               sc_set_float = 1'b1;
               sc_phase     = PH_FRAC;
            end else begin
               sc_fail = 1'b1;
            end
         end
         PH_FRAC: begin
            priority if (is_digit(sym_chr)) begin
               sc_grow = 2'd1;
            end else if (sym_chr == CH_F) begin
               sc_grow  = 2'd1;
               sc_phase = PH_F;
            end else begin
               sc_fail = 1'b1;
            end
         end
         PH_F: begin
            priority if (sym_chr == CH_3) begin
               sc_hold  = 1'b1;
               sc_phase = PH_F3;
            end else if (sym_chr == CH_6) begin
               sc_hold  = 1'b1;
               sc_phase = PH_F6;
            end else begin
               sc_fail = 1'b1;
            end
         end
         PH_F3: begin
            if (sym_chr == CH_2) sc_grow = 2'd2;
            else sc_fail = 1'b1;
         end
         PH_F6: begin
            if (sym_chr == CH_4) sc_grow = 2'd2;
            else sc_fail = 1'b1;
         end
         PH_SU: begin
            priority if (sym_chr == CH_8) begin
               sc_grow = 2'd2;
            end else if (sym_chr == CH_1) begin
               sc_hold  = 1'b1;
               sc_phase = PH_SU1;
            end else if (sym_chr == CH_3) begin
               sc_hold  = 1'b1;
               sc_phase = PH_SU3;
            end else if (sym_chr == CH_6) begin
               sc_hold  = 1'b1;
               sc_phase = PH_SU6;
            end else begin
               sc_fail = 1'b1;
            end
         end
         PH_SU1: begin
            if (sym_chr == CH_6) sc_grow = 2'd3;
            else sc_fail = 1'b1;
         end
         PH_SU3: begin
            if (sym_chr == CH_2) sc_grow = 2'd3;
            else sc_fail = 1'b1;
         end
         PH_SU6: begin
            if (sym_chr == CH_4) sc_grow = 2'd3;
            else sc_fail = 1'b1;
         end
         default: begin
            sc_phase = PH_IDLE;
         end
      endcase

      // a suffix closes the literal once its last character arrives
      if (!sc_fail && (sc_grow != 2'd0) && (phase_ff != PH_INT) && (phase_ff != PH_DOT)
          && (phase_ff != PH_FRAC)) begin
         sc_la_clr  = 1'b1;
         sc_lit_tok = 1'b1;
         sc_emit    = 1'b1;
         sc_phase   = PH_IDLE;
      end
      // literal ends before this symbol: emit it and rescan the held characters
      if (sc_fail) begin
         sc_consume = 1'b0;
         sc_lit_tok = 1'b1;
         sc_emit    = 1'b1;
         sc_phase   = PH_IDLE;
      end
      sc_end_done = sym_end && sc_consume;
   end

   always_comb begin
      len_sum   = {1'b0, lit_len_ff} + (TOK_W+1)'(sc_grow);
      len_grown = len_sum[TOK_W] ? '1 : len_sum[TOK_W-1:0];
      if (sc_lit_tok) begin
         tok.kind  = lit_float_ff ? TK_FLOAT : TK_INT;
         tok.start = lit_start_ff;
         tok.len   = len_grown;
      end else begin
         tok.kind  = sc_kind;
         tok.start = sym_off;
         tok.len   = sc_len;
      end
   end

   assign out_free          = !out_vld_ff || rsp_ready;
   assign status.sym_avail  = from_replay || chr_pend_ff || end_pend_ff;
   assign status.step_block = sc_emit && stg_vld_ff && !out_free;
   assign status.stg_valid  = stg_vld_ff;
   assign status.out_free   = out_free;

   // scanner control state
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= '0;
         phase_ff     <= PH_IDLE;
         lit_start_ff <= '0;
         lit_len_ff   <= '0;
         lit_float_ff <= 1'b0;
         la_cnt_ff    <= '0;
         rp_ff        <= '0;
         rcnt_ff      <= '0;
         chr_pend_ff  <= 1'b0;
         end_pend_ff  <= 1'b0;
      end else if (cmd.load) begin
         chr_pend_ff <= req_data.char_valid;
         end_pend_ff <= req_data.end_of_source;
         if (req_data.char_valid && (off_ff != '1)) begin
            off_ff <= off_ff + OFF_W'(1);
         end
      end else if (cmd.step) begin
         if (sc_end_done) begin
            // source ends: back to the reset state for the next source
            off_ff       <= '0;
            phase_ff     <= PH_IDLE;
            lit_start_ff <= '0;
            lit_len_ff   <= '0;
            lit_float_ff <= 1'b0;
            la_cnt_ff    <= '0;
            rp_ff        <= '0;
            rcnt_ff      <= '0;
            end_pend_ff  <= 1'b0;
         end else begin
            phase_ff <= sc_phase;
            if (from_replay && sc_consume) begin
               rp_ff <= rp_ff + 2'd1;
            end
            if (from_chr && sc_consume) begin
               chr_pend_ff <= 1'b0;
            end
            if (sc_begin) begin
               lit_start_ff <= sym_off;
               lit_len_ff   <= TOK_W'(1);
               lit_float_ff <= 1'b0;
            end else begin
               lit_len_ff <= len_grown;
               if (sc_set_float) lit_float_ff <= 1'b1;
            end
            priority if (sc_fail) begin
               rcnt_ff   <= la_cnt_ff;
               rp_ff     <= '0;
               la_cnt_ff <= '0;
            end else if (sc_la_clr) begin
               la_cnt_ff <= '0;
            end else if (sc_hold && (la_cnt_ff != 2'(LA_N))) begin
               la_cnt_ff <= la_cnt_ff + 2'd1;
            end else begin
               la_cnt_ff <= la_cnt_ff;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_chr_ff <= req_data.char_code;
         in_off_ff <= TOK_W'(off_ff);
      end
      if (cmd.step && sc_hold && !sc_end_done && (la_cnt_ff != 2'(LA_N))) begin
         la_chr_ff[la_cnt_ff] <= sym_chr;
         la_off_ff[la_cnt_ff] <= sym_off;
      end
   end

   // held token: the previous one leaves once a newer one shows it was not last
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (cmd.step && sc_emit) begin
            stg_vld_ff <= 1'b1;
            if (stg_vld_ff) begin
               out_vld_ff <= 1'b1;
            end else if (rsp_ready) begin
               out_vld_ff <= 1'b0;
            end
         end else if (cmd.flush) begin
            stg_vld_ff <= 1'b0;
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && sc_emit) begin
         stg_ff <= tok;
         if (stg_vld_ff) begin
            out_ff <= '{token_kind: stg_ff.kind, token_start: stg_ff.start,
                        token_length: stg_ff.len, last_result: 1'b0};
         end
      end else if (cmd.flush) begin
         out_ff <= '{token_kind: stg_ff.kind, token_start: stg_ff.start,
                     token_length: stg_ff.len, last_result: 1'b1};
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

>>> hdl/numeric_literal_tokenizer.sv
// Top level of the numeric literal tokenizer: controller plus datapath.
// Depends on nlt_pkg, nlt_ctrl and nlt_dp.
//
// One request per source byte (and/or an end-of-source mark) goes in; zero to six
// tokens come out, the last one of each request flagged by last_result. Whitespace is
// skipped, '+', '-' and ';' give one-character tokens, digit runs give integer
// literals, a dot plus digits gives a float, and f/f32/f64 or s8..u64 suffixes are
// absorbed; partial suffixes and a bare dot are replayed from a three-entry lookahead.
// End of source flushes any open literal, gives an end token and restarts offsets at
// zero. The controller walks one symbol per clock through the scanner unless the result
// side holds it back: a request is taken only in idle, then each scanned symbol (its
// own byte, the end mark, each replayed lookahead byte and each rescan after a literal
// closes) is stepped, after which the controller sees that no symbol is left and
// releases the last token of the request.
// Offsets saturate at 2^OFFSET_BITS-1, and at 65535 for widths of 16 and above.
module numeric_literal_tokenizer #(
   parameter int OFFSET_BITS = nlt_pkg::OFFSET_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nlt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nlt_pkg::rsp_type rsp_data
);
   import nlt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   nlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nlt_dp #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/nlt_checker.sv
// Port-level checks for the numeric literal tokenizer, bound to the top level.
// Depends on nlt_pkg and numeric_literal_tokenizer.
module nlt_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input nlt_pkg::rsp_type rsp_data
);
   import nlt_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result presented straight after reset");

   // the end token closes its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_kind == TK_END) |-> rsp_data.last_result)
      else $error("end token not marked last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.token_kind == TK_END) || (rsp_data.token_kind == TK_INVALID))
      |-> (rsp_data.token_length == '0))
      else $error("empty token with non-zero length");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.token_kind == TK_PLUS) || (rsp_data.token_kind == TK_MINUS)
                    || (rsp_data.token_kind == TK_SEMI))
      |-> (rsp_data.token_length == 16'd1))
      else $error("single-character token with wrong length");

endmodule

bind numeric_literal_tokenizer nlt_checker u_nlt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> dv/testbench.sv
// Self-checking testbench for numeric_literal_tokenizer: random handshakes on both sides,
// an in-bench tokenizer that predicts tokens for all but typed rows, and a field-by-field scoreboard.
// Depends on nlt_pkg and the numeric_literal_tokenizer RTL.
module testbench;
   import nlt_pkg::*;

   localparam int NLT_OFF_BITS   = OFFSET_BITS_DEF;
   localparam int OFF_LIMIT      = (NLT_OFF_BITS < 16) ? (1 << NLT_OFF_BITS) - 1 : 65535;
   localparam int END_MARK       = 256;
   localparam int MAX_TOKENS     = 6;
   localparam int RANDOM_ITEMS   = 390;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_RUN       = 16;

   typedef struct {
      logic [7:0]     code;
      bit             has_char;
      bit             ends;
      bit             typed;
      token_kind_type kind;
      int             start;
      int             len;
   } lex_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type pending_tokens[$];
   rsp_type expected_token;
   int      error_count  = 0;
   int      quiet_cycles = 0;
   int      random_items = 0;
   bit      steady_flow  = 1'b0;
   bit      hold_results = 1'b0;

   // tokenizer state
   logic [15:0]    scan_offset;
   scan_phase_type scan_state;
   logic [15:0]    lit_start;
   logic [15:0]    lit_len;
   bit             lit_float;
   int             held_sym[3];
   logic [15:0]    held_off[3];
   int             held_cnt;
   rsp_type        step_toks[$];

   string      suffixes[] = '{"f", "f32", "f64", "s8", "s16", "s32", "s64", "u8", "u16",
                              "u32", "u64", "f3", "f6", "s", "u", "s1", "s3", "s6", "u1",
                              "u3", "u6", "s7", "f33"};
   logic [7:0] blanks[]    = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   logic [7:0] operators[] = '{CH_PLUS, CH_MINUS, CH_SEMI};
   logic [7:0] fragments[] = '{CH_DOT, CH_F, CH_S, CH_U};

   lex_row_type directed_rows[] = '{
      '{CH_PLUS,  1'b1, 1'b0, 1'b1, TK_PLUS,    0, 1},
      '{CH_MINUS, 1'b1, 1'b0, 1'b1, TK_MINUS,   1, 1},
      '{CH_SEMI,  1'b1, 1'b0, 1'b1, TK_SEMI,    2, 1},
      '{CH_NUL,   1'b1, 1'b0, 1'b1, TK_INVALID, 3, 0},
      '{8'hFF,    1'b1, 1'b0, 1'b1, TK_INVALID, 4, 0},
      '{8'h20,    1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_1,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_2,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_DOT,   1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{8'h35,    1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_F,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_6,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_4,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_9,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_U,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_1,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_6,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{8'h37,    1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_DOT,   1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_PLUS,  1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_3,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_S,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_3,     1'b1, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_NUL,   1'b0, 1'b1, 1'b0, TK_END,     0, 0},
      '{8'hA5,    1'b0, 1'b0, 1'b0, TK_END,     0, 0},
      '{CH_NUL,   1'b0, 1'b1, 1'b1, TK_END,     0, 0},
      '{CH_0,     1'b1, 1'b1, 1'b0, TK_END,     0, 0}
   };

   numeric_literal_tokenizer #(
      .OFFSET_BITS(NLT_OFF_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- tokenizer
   function automatic void clear_scanner();
      scan_offset = '0;
      scan_state  = PH_IDLE;
      lit_start   = '0;
      lit_len     = '0;
      lit_float   = 1'b0;
      held_cnt    = 0;
   endfunction

   function automatic void put_token(token_kind_type k, logic [15:0] s, logic [15:0] l);
      rsp_type t;
      t.token_kind   = k;
      t.token_start  = s;
      t.token_length = l;
      t.last_result  = 1'b0;
      if (step_toks.size() < MAX_TOKENS) step_toks.push_back(t);
   endfunction

   function automatic void extend_literal(int n);
      lit_len = (int'(lit_len) + n > 65535) ? 16'hFFFF : 16'(int'(lit_len) + n);
   endfunction

   function automatic void hold_symbol(int s, logic [15:0] o, scan_phase_type nxt);
      if (held_cnt < 3) begin
         held_sym[held_cnt] = s;
         held_off[held_cnt] = o;
         held_cnt++;
      end
      scan_state = nxt;
   endfunction

   function automatic void close_literal();
      put_token(lit_float ? TK_FLOAT : TK_INT, lit_start, lit_len);
      scan_state = PH_IDLE;
   endfunction

   function automatic void close_suffix(int n);
      extend_literal(n);
      held_cnt = 0;
      close_literal();
   endfunction

   // Returns 0 when the literal was closed and the held symbols must be scanned again.
   function automatic bit scan_one(int s, logic [15:0] o);
      bit dig;
      bit blank;
      dig   = (s >= 'h30) && (s <= 'h39);
      blank = (s == 'h20) || ((s >= 'h09) && (s <= 'h0D));
      case (scan_state)
         PH_IDLE: begin
            if (s == END_MARK) put_token(TK_END, o, 16'd0);
            else if (blank) ;
            else if (s == CH_PLUS) put_token(TK_PLUS, o, 16'd1);
            else if (s == CH_MINUS) put_token(TK_MINUS, o, 16'd1);
            else if (s == CH_SEMI) put_token(TK_SEMI, o, 16'd1);
            else if (dig) begin
               scan_state = PH_INT;
               lit_start  = o;
               lit_len    = 16'd1;
               lit_float  = 1'b0;
            end else put_token(TK_INVALID, o, 16'd0);
            return 1'b1;
         end
         PH_INT: begin
            if (dig) begin
               extend_literal(1);
               return 1'b1;
            end
            if (s == CH_DOT) begin
               hold_symbol(s, o, PH_DOT);
               return 1'b1;
            end
            if (s == CH_F) begin
               extend_literal(1);
               lit_float  = 1'b1;
               scan_state = PH_F;
               return 1'b1;
            end
            if (s == CH_S || s == CH_U) begin
               hold_symbol(s, o, PH_SU);
               return 1'b1;
            end
         end
         PH_DOT: begin
            if (dig) begin
               extend_literal(2);
               held_cnt   = 0;
               lit_float  = 1'b1;
               scan_state = PH_FRAC;
               return 1'b1;
            end
         end
         PH_FRAC: begin
            if (dig) begin
               extend_literal(1);
               return 1'b1;
            end
            if (s == CH_F) begin
               extend_literal(1);
               scan_state = PH_F;
               return 1'b1;
            end
         end
         PH_F: begin
            if (s == CH_3) begin
               hold_symbol(s, o, PH_F3);
               return 1'b1;
            end
            if (s == CH_6) begin
               hold_symbol(s, o, PH_F6);
               return 1'b1;
            end
         end
         PH_F3: begin
            if (s == CH_2) begin
               close_suffix(2);
               return 1'b1;
            end
         end
         PH_F6: begin
            if (s == CH_4) begin
               close_suffix(2);
               return 1'b1;
            end
         end
         PH_SU: begin
            if (s == CH_8) begin
               close_suffix(2);
               return 1'b1;
            end
            if (s == CH_1) begin
               hold_symbol(s, o, PH_SU1);
               return 1'b1;
            end
            if (s == CH_3) begin
               hold_symbol(s, o, PH_SU3);
               return 1'b1;
            end
            if (s == CH_6) begin
               hold_symbol(s, o, PH_SU6);
               return 1'b1;
            end
         end
         PH_SU1: begin
            if (s == CH_6) begin
               close_suffix(3);
               return 1'b1;
            end
         end
         PH_SU3: begin
            if (s == CH_2) begin
               close_suffix(3);
               return 1'b1;
            end
         end
         PH_SU6: begin
            if (s == CH_4) begin
               close_suffix(3);
               return 1'b1;
            end
         end
         default: ;
      endcase
      close_literal();
      return 1'b0;
   endfunction

   task automatic tokenize_request(input req_type r, output rsp_type toks[$]);
      int          syms[$];
      logic [15:0] offs[$];
      int          rescan_sym[$];
      logic [15:0] rescan_off[$];
      int          i;
      step_toks = {};
      if (r.char_valid) begin
         syms.push_back(int'(r.char_code));
         offs.push_back(scan_offset);
         if (int'(scan_offset) < OFF_LIMIT) scan_offset++;
      end
      if (r.end_of_source) begin
         syms.push_back(END_MARK);
         offs.push_back(scan_offset);
      end
      i = 0;
      while (i < syms.size()) begin
         if (scan_one(syms[i], offs[i])) begin
            i++;
         end else begin
            // replay held symbols ahead of whatever is still unscanned
            rescan_sym = {};
            rescan_off = {};
            for (int k = 0; k < held_cnt; k++) begin
               rescan_sym.push_back(held_sym[k]);
               rescan_off.push_back(held_off[k]);
            end
            held_cnt = 0;
            for (int k = i; k < syms.size(); k++) begin
               rescan_sym.push_back(syms[k]);
               rescan_off.push_back(offs[k]);
            end
            syms = rescan_sym;
            offs = rescan_off;
            i    = 0;
         end
      end
      if (r.end_of_source) clear_scanner();
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].last_result = 1'b1;
      toks = step_toks;
   endtask

   // ---------------------------------------------------------------- request side
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_tok);
      int      gap;
      rsp_type toks[$];
      gap = 0;
      if (!steady_flow && $urandom_range(0, 99) < 30)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tokenize_request(r, toks);
      if (typed) pending_tokens.push_back(typed_tok);
      else foreach (toks[k]) pending_tokens.push_back(toks[k]);
   endtask

   task automatic send_char(input logic [7:0] c, input bit has_char, input bit ends);
      req_type r;
      r.char_code     = c;
      r.char_valid    = has_char;
      r.end_of_source = ends;
      send_request(r, 1'b0, '0);
   endtask

   // Pause the request side until every predicted token has come out.
   task automatic drain_tokens();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
   endtask

   task automatic play_random_source();
      logic [7:0] src[$];
      string      sx;
      int         n_lex;
      int         pick;
      int         k;
      bit         end_on_char;
      n_lex = $urandom_range(2, 8);
      for (int t = 0; t < n_lex; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            k = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 3);
            repeat (k) src.push_back(8'(CH_0 + $urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0) begin
               src.push_back(CH_DOT);
               // leave the dot bare now and then
               if ($urandom_range(0, 4) != 0)
                  repeat ($urandom_range(1, 3)) src.push_back(8'(CH_0 + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 4) < 2) begin
               sx = suffixes[$urandom_range(0, suffixes.size() - 1)];
               for (int j = 0; j < sx.len(); j++) src.push_back(sx[j]);
            end
         end else if (pick < 70) begin
            src.push_back(operators[$urandom_range(0, 2)]);
         end else if (pick < 80) begin
            src.push_back(blanks[$urandom_range(0, 5)]);
         end else if (pick < 90) begin
            src.push_back(fragments[$urandom_range(0, 3)]);
         end else begin
            src.push_back(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 1) == 1) src.push_back(blanks[$urandom_range(0, 5)]);
      end
      end_on_char = ($urandom_range(0, 1) == 1);
      for (int j = 0; j < src.size(); j++) begin
         if ($urandom_range(0, 19) == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_char(src[j], 1'b1, end_on_char && (j == src.size() - 1));
         random_items++;
      end
      if (!end_on_char) begin
         send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         random_items++;
      end
   endtask

   // ---------------------------------------------------------------- result side
   initial begin
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
         end else if (steady_flow || $urandom_range(0, 99) >= 25) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2))
               @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tokens.size() == 0) begin
            $error("unexpected token: kind %0d start %0d length %0d", rsp_data.token_kind,
                   rsp_data.token_start, rsp_data.token_length);
            error_count++;
         end else begin
            expected_token = pending_tokens.pop_front();
            if (rsp_data.token_kind !== expected_token.token_kind) begin
               $error("token_kind: expected %0d, got %0d", expected_token.token_kind,
                      rsp_data.token_kind);
               error_count++;
            end
            if (rsp_data.token_start !== expected_token.token_start) begin
               $error("token_start: expected %0d, got %0d", expected_token.token_start,
                      rsp_data.token_start);
               error_count++;
            end
            if (rsp_data.token_length !== expected_token.token_length) begin
               $error("token_length: expected %0d, got %0d", expected_token.token_length,
                      rsp_data.token_length);
               error_count++;
            end
            if (rsp_data.last_result !== expected_token.last_result) begin
               $error("last_result: expected %0d, got %0d", expected_token.last_result,
                      rsp_data.last_result);
               error_count++;
            end
         end
      end
   end

   // Count cycles in which neither channel moves anything.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("numeric_literal_tokenizer verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus
   initial begin
      req_type r;
      rsp_type t;
      bit      pressure_done;
      clear_scanner();
      pressure_done = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r.char_code     = directed_rows[i].code;
         r.char_valid    = directed_rows[i].has_char;
         r.end_of_source = directed_rows[i].ends;
         t.token_kind    = directed_rows[i].kind;
         t.token_start   = 16'(directed_rows[i].start);
         t.token_length  = 16'(directed_rows[i].len);
         t.last_result   = 1'b1;
         send_request(r, directed_rows[i].typed, t);
      end
      drain_tokens();

      // one long literal, offered back to back
      steady_flow = 1'b1;
      repeat (LONG_RUN) send_char(8'(CH_0 + $urandom_range(0, 9)), 1'b1, 1'b0);
      send_char(CH_PLUS, 1'b1, 1'b1);
      drain_tokens();
      steady_flow = 1'b0;

      while (random_items < RANDOM_ITEMS) begin
         if (!pressure_done && random_items > RANDOM_ITEMS / 2) begin
            // hold the result side off and keep offering requests until input stalls
            drain_tokens();
            hold_results = 1'b1;
            steady_flow  = 1'b1;
            repeat (24) begin
               send_char(operators[$urandom_range(0, 2)], 1'b1, 1'b0);
               random_items++;
            end
            send_char(CH_NUL, 1'b0, 1'b1);
            steady_flow   = 1'b0;
            pressure_done = 1'b1;
         end
         steady_flow = ($urandom_range(0, 6) == 0);
         play_random_source();
         steady_flow = 1'b0;
         if ($urandom_range(0, 6) == 0) drain_tokens();
      end

      drain_tokens();
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("numeric_literal_tokenizer verification clean");
      else $display("numeric_literal_tokenizer verification failed");
      $finish;
   end

endmodule
